FILE: hw/rtl/mm4x4_pkg.sv
`default_nettype none

package mm4x4_pkg;

  // Field widths of the request and result channels
  localparam int OPC_W  = 2;
  localparam int FIDX_W = 2;
  localparam int DATA_W = 32;

  typedef logic [OPC_W-1:0]         opcode_t;
  typedef logic [FIDX_W-1:0]        fidx_t;
  typedef logic signed [DATA_W-1:0] elem_t;

  // Request opcodes
  localparam opcode_t OP_LOAD_LEFT  = 2'd0;
  localparam opcode_t OP_LOAD_RIGHT = 2'd1;
  localparam opcode_t OP_MULTIPLY   = 2'd2;

endpackage

`default_nettype wire

FILE: hw/rtl/mm4x4_in_if.sv
`default_nettype none

interface mm4x4_in_if import mm4x4_pkg::*; ();
  logic    valid;
  logic    ready;
  opcode_t opcode;
  fidx_t   row;
  fidx_t   col;
  elem_t   value;

  modport source (output valid, output opcode, output row, output col, output value,
                  input ready);
  modport sink   (input valid, input opcode, input row, input col, input value,
                  output ready);
endinterface

`default_nettype wire

FILE: hw/rtl/mm4x4_out_if.sv
`default_nettype none

interface mm4x4_out_if import mm4x4_pkg::*; ();
  logic  valid;
  logic  ready;
  fidx_t out_row;
  fidx_t out_col;
  elem_t product;
  logic  saturated;
  logic  last;

  modport source (output valid, output out_row, output out_col, output product,
                  output saturated, output last, input ready);
  modport sink   (input valid, input out_row, input out_col, input product,
                  input saturated, input last, output ready);
endinterface

`default_nettype wire

FILE: hw/rtl/matrix4x4_multiply.sv
`default_nettype none

// Fixed-point DIM x DIM matrix multiplier. Load requests write one signed Q16.16
// element of the left or right matrix, each held in its own memory with one write
// and one read port; a load whose row or column lies outside the matrix, and the
// unused opcode, change nothing. A multiply request emits the DIM*DIM elements of
// left times right in row-major order, with last set on the final one. Each
// element is the exact sum of DIM 64-bit products, shifted right by FRAC_BITS
// (rounding toward minus infinity) and saturated to 32 bits, with saturated set
// when clipped. Elements are computed one at a time, the next starting only after
// the last is handed off: DIM reads through the one read port of each memory,
// then the multiply, accumulate and saturate stages. A multiply request occupies
// the block until its final element enters the output register; result stalls delay it.
// Requests are taken only between multiplies. Both matrices read as zero after
// reset until their elements are loaded; no clearing pass is needed.
module matrix4x4_multiply import mm4x4_pkg::*; #(
  parameter int DIM       = 4,
  parameter int FRAC_BITS = 16
) (
  input  wire logic         clk,
  input  wire logic         rst_n,
  mm4x4_in_if.sink          in_ch,
  mm4x4_out_if.source       out_ch
);

  localparam int DEPTH  = DIM * DIM;
  localparam int ADDR_W = $clog2(DEPTH);
  localparam int IDX_W  = $clog2(DIM);
  localparam int PROD_W = 2 * DATA_W;
  localparam int ACC_W  = PROD_W + $clog2(DIM);

  localparam logic [1:0] S_IDLE  = 2'd0;
  localparam logic [1:0] S_ISSUE = 2'd1;
  localparam logic [1:0] S_WAIT  = 2'd2;

  localparam logic [IDX_W-1:0] IDX_LAST = IDX_W'(DIM - 1);
  localparam logic [IDX_W-1:0] IDX_ONE  = IDX_W'(1);

  logic [1:0] state_r, state_nxt;
  logic [IDX_W-1:0] r_r, c_r, k_r;

  // Matrix memories and their written flags
  elem_t left_mem  [DEPTH];
  elem_t right_mem [DEPTH];
  logic [DEPTH-1:0] lvld_r, rvld_r;

  elem_t l_q_r, r_q_r;
  logic  lv_q_r, rv_q_r;
  logic  rd_vld_r, rd_first_r, rd_last_r;

  logic signed [PROD_W-1:0] prod_r;
  logic mul_vld_r, mul_first_r, mul_last_r;

  logic signed [ACC_W-1:0] acc_r;
  logic done_r;

  logic  out_valid_r;
  fidx_t out_row_r, out_col_r;
  elem_t out_prod_r;
  logic  out_sat_r, out_last_r;

  logic in_acc, ld_ok, out_load, elem_last;
  logic [ADDR_W-1:0] ld_addr;
  logic [ADDR_W-1:0] l_raddr, r_raddr;
  elem_t l_op, r_op;
  logic signed [ACC_W-1:0] sh;
  logic [ACC_W-32:0] sh_top;
  logic sat;

  assign in_ch.ready = (state_r == S_IDLE);
  assign in_acc      = in_ch.valid && in_ch.ready;
  assign ld_ok       = (32'(in_ch.row) < 32'(DIM)) && (32'(in_ch.col) < 32'(DIM));
  assign ld_addr     = ADDR_W'(in_ch.row) * ADDR_W'(DIM) + ADDR_W'(in_ch.col);
  assign l_raddr     = ADDR_W'(r_r) * ADDR_W'(DIM) + ADDR_W'(k_r);
  assign r_raddr     = ADDR_W'(k_r) * ADDR_W'(DIM) + ADDR_W'(c_r);
  assign out_load    = done_r && (!out_valid_r || out_ch.ready);
  assign elem_last   = (r_r == IDX_LAST) && (c_r == IDX_LAST);

  // Write on load requests, read both memories every cycle
  always_ff @(posedge clk) begin
    if (in_acc && ld_ok && in_ch.opcode == OP_LOAD_LEFT) begin
      left_mem[ld_addr] <= in_ch.value;
    end
    if (in_acc && ld_ok && in_ch.opcode == OP_LOAD_RIGHT) begin
      right_mem[ld_addr] <= in_ch.value;
    end
    l_q_r  <= left_mem[l_raddr];
    r_q_r  <= right_mem[r_raddr];
  end

  // Track which entries hold loaded data
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      lvld_r <= '0;
      rvld_r <= '0;
      lv_q_r <= 1'b0;
      rv_q_r <= 1'b0;
    end else begin
      if (in_acc && ld_ok && in_ch.opcode == OP_LOAD_LEFT) begin
        lvld_r[ld_addr] <= 1'b1;
      end
      if (in_acc && ld_ok && in_ch.opcode == OP_LOAD_RIGHT) begin
        rvld_r[ld_addr] <= 1'b1;
      end
      lv_q_r <= lvld_r[l_raddr];
      rv_q_r <= rvld_r[r_raddr];
    end
  end

  // Sequencer
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      S_IDLE: begin
        if (in_acc && in_ch.opcode == OP_MULTIPLY) state_nxt = S_ISSUE;
      end
      S_ISSUE: begin
        if (k_r == IDX_LAST) state_nxt = S_WAIT;
      end
      S_WAIT: begin
        if (out_load) state_nxt = elem_last ? S_IDLE : S_ISSUE;
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      r_r     <= '0;
      c_r     <= '0;
      k_r     <= '0;
    end else begin
      state_r <= state_nxt;
      case (state_r)
        S_IDLE: begin
          r_r <= '0;
          c_r <= '0;
          k_r <= '0;
        end
        S_ISSUE: begin
          k_r <= (k_r == IDX_LAST) ? '0 : k_r + IDX_ONE;
        end
        S_WAIT: begin
          // advance to the next element once this one is handed off
          if (out_load && !elem_last) begin
            if (c_r == IDX_LAST) begin
              c_r <= '0;
              r_r <= r_r + IDX_ONE;
            end else begin
              c_r <= c_r + IDX_ONE;
            end
          end
        end
        default: ;
      endcase
    end
  end

  // Multiply-accumulate pipeline control
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rd_vld_r  <= 1'b0;
      mul_vld_r <= 1'b0;
      done_r    <= 1'b0;
    end else begin
      rd_vld_r  <= (state_r == S_ISSUE);
      mul_vld_r <= rd_vld_r;
      if (mul_vld_r && mul_last_r) begin
        done_r <= 1'b1;
      end else if (out_load) begin
        done_r <= 1'b0;
      end
    end
  end

  // Unwritten entries read as zero
  assign l_op = lv_q_r ? l_q_r : '0;
  assign r_op = rv_q_r ? r_q_r : '0;

  always_ff @(posedge clk) begin
    rd_first_r  <= (k_r == '0);
    rd_last_r   <= (k_r == IDX_LAST);
    prod_r      <= PROD_W'(l_op) * PROD_W'(r_op);
    mul_first_r <= rd_first_r;
    mul_last_r  <= rd_last_r;
    if (mul_vld_r) begin
      acc_r <= mul_first_r ? ACC_W'(prod_r) : acc_r + ACC_W'(prod_r);
    end
  end

  // Drop fraction bits, then saturate to 32 bits
  assign sh     = acc_r >>> FRAC_BITS;
  assign sh_top = sh[ACC_W-1:31];
  assign sat    = !((&sh_top) || (~|sh_top));

  // Output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (out_load) begin
      out_valid_r <= 1'b1;
    end else if (out_ch.ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      out_row_r  <= FIDX_W'(r_r);
      out_col_r  <= FIDX_W'(c_r);
      out_prod_r <= sat ? (sh[ACC_W-1] ? 32'sh8000_0000 : 32'sh7FFF_FFFF) : sh[31:0];
      out_sat_r  <= sat;
      out_last_r <= elem_last;
    end
  end

  assign out_ch.valid     = out_valid_r;
  assign out_ch.out_row   = out_row_r;
  assign out_ch.out_col   = out_col_r;
  assign out_ch.product   = out_prod_r;
  assign out_ch.saturated = out_sat_r;
  assign out_ch.last      = out_last_r;

`ifndef SYNTH
  a_mul_starts: assert property (@(posedge clk) disable iff (!rst_n)
    (in_acc && in_ch.opcode == OP_MULTIPLY) |=> state_r == S_ISSUE)
    else $error("multiply request did not start the sequencer");

  a_pipe_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (mul_vld_r || done_r) |-> state_r == S_WAIT || state_r == S_ISSUE)
    else $error("pipeline active while idle");

  a_last_idle: assert property (@(posedge clk) disable iff (!rst_n)
    (out_load && elem_last) |=> state_r == S_IDLE && out_ch.valid && out_ch.last)
    else $error("final element did not end the run");

  a_sat_value: assert property (@(posedge clk) disable iff (!rst_n)
    (out_ch.valid && out_ch.saturated) |->
      out_ch.product == 32'sh7FFF_FFFF || out_ch.product == 32'sh8000_0000)
    else $error("saturated element is not a range limit");

  a_load_quiet: assert property (@(posedge clk) disable iff (!rst_n)
    (in_acc && in_ch.opcode != OP_MULTIPLY && !out_ch.valid) |=> !out_ch.valid)
    else $error("load request produced a result");
`endif

endmodule

`default_nettype wire
